[hw/rtl/axis_rate_level_pid_top_assert.svh]
// Assertion macros for the axis PID controller
`ifndef AXIS_RATE_LEVEL_PID_TOP_ASSERT_SVH
`define AXIS_RATE_LEVEL_PID_TOP_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define ARLP_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define ARLP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/arlp_pkg.sv]
// Shared types and constants of the axis PID controller
`default_nettype none

package arlp_pkg;

   localparam int DATA_W = 16;
   localparam int GAIN_W = 24;
   localparam int TRIM_W = 10;
   localparam int TILT_W = 12;
   localparam int INT_W  = 15;
   localparam int PROD_W = 24;

   typedef enum logic [2:0] {
      REG_GAINS_ROLL  = 3'd0,
      REG_GAINS_PITCH = 3'd1,
      REG_GAINS_YAW   = 3'd2,
      REG_GAINS_LEVEL = 3'd3,
      REG_TRIM_ROLL   = 3'd4,
      REG_TRIM_PITCH  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      AXIS_ROLL  = 2'd0,
      AXIS_PITCH = 2'd1,
      AXIS_YAW   = 2'd2,
      AXIS_NONE  = 2'd3
   } axis_type;

   localparam logic [GAIN_W-1:0] GAINS_ROLL_RST  = 24'h281E17;
   localparam logic [GAIN_W-1:0] GAINS_PITCH_RST = 24'h281E17;
   localparam logic [GAIN_W-1:0] GAINS_YAW_RST   = 24'h552D00;
   localparam logic [GAIN_W-1:0] GAINS_LEVEL_RST = 24'h5A0A64;

   localparam logic [7:0] CMD_SCALE   = 8'd80;
   localparam logic [2:0] P_CLAMP_MUL = 3'd5;

   // reciprocals of 80, 100 and 125 scaled by 2**RECIP_SHIFT, rounded up;
   // exact for the operand magnitudes that reach them (below 2**23)
   localparam int                RECIP_SHIFT = 30;
   localparam logic [PROD_W-1:0] RECIP_80    = 24'd13421773;
   localparam logic [PROD_W-1:0] RECIP_100   = 24'd10737419;
   localparam logic [PROD_W-1:0] RECIP_125   = 24'd8589935;

   localparam logic signed [10:0] CMD_CLAMP     = 11'sd500;
   localparam logic signed [14:0] LEVEL_INT_MAX = 15'sd10000;
   localparam logic signed [14:0] RATE_INT_MAX  = 15'sd16000;
   localparam logic signed [15:0] GYRO_CUT      = 16'sd640;

   localparam int LEVEL_I_SHIFT = 12;
   localparam int RATE_I_SHIFT  = 6;
   localparam int D_SHIFT       = 5;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_LOAD,
      S_MUL_A,
      S_DIV_A,
      S_INT,
      S_DIV_B,
      S_MUL_B,
      S_MUL_C,
      S_DIV_C,
      S_DEL,
      S_MUL_D,
      S_OUT
   } pid_state_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] prev_gyro;
      logic signed [DATA_W-1:0] older_delta;
      logic signed [DATA_W-1:0] oldest_delta;
      logic signed [INT_W-1:0]  rate_int;
      logic signed [INT_W-1:0]  angle_int;
   } entry_type;

   typedef struct packed {
      logic       rd_en;
      logic       wr_en;
      logic       clr_angle;
      logic [1:0] addr;
   } mem_ctl_type;

endpackage

`default_nettype wire

[hw/rtl/arlp_state_mem.sv]
// Per-axis state memory with entry and angle-integral valid bits
`default_nettype none

module arlp_state_mem
   import arlp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mem_ctl_type ctl,
   input  wire entry_type   wr_data,
   output entry_type        rd_data
);

   localparam int DEPTH = 3;

   entry_type        mem_ff [DEPTH];
   entry_type        rd_ff;
   logic [DEPTH-1:0] ok_ff;
   logic [1:0]       aok_ff;
   logic             rd_ok_ff;
   logic             rd_aok_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[ctl.addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_ff <= mem_ff[ctl.addr];
      end
   end

   // unwritten entries read as zero; angle bits also dropped on a clear
   always_ff @(posedge clock) begin
      if (reset) begin
         ok_ff     <= '0;
         aok_ff    <= '0;
         rd_ok_ff  <= 1'b0;
         rd_aok_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            ok_ff[ctl.addr] <= 1'b1;
         end
         if (ctl.clr_angle) begin
            aok_ff <= '0;
         end else if (ctl.wr_en && ctl.addr != AXIS_YAW) begin
            aok_ff[ctl.addr[0]] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_ok_ff  <= ok_ff[ctl.addr];
            rd_aok_ff <= (ctl.addr != AXIS_YAW) && aok_ff[ctl.addr[0]];
         end
      end
   end

   always_comb begin
      rd_data = rd_ff;
      if (!rd_ok_ff) begin
         rd_data = '0;
      end
      if (!rd_aok_ff) begin
         rd_data.angle_int = '0;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/arlp_divider.sv]
// Signed truncating divider, 24-bit dividend by 8-bit divisor, two bits a cycle
`default_nettype none

module arlp_divider
   import arlp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [PROD_W-1:0] dividend,
   input  wire logic        [7:0]        divisor,
   output logic                          done,
   output logic signed [PROD_W-1:0]      quotient
);

   localparam int ITER  = PROD_W / 2;
   localparam int CNT_W = $clog2(ITER + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [PROD_W-1:0] mag_ff;
   logic [PROD_W-1:0] mag_in;
   logic [7:0]        rem_ff;
   logic [7:0]        rem_in;
   logic [7:0]        div_ff;
   logic              neg_ff;
   logic [8:0]        s1;
   logic [8:0]        s2;

   // one restoring step: returns {quotient bit, remainder}
   function automatic logic [8:0] div_step(input logic [7:0] rem, input logic b,
                                           input logic [7:0] d);
      logic [8:0] t;
      t = {rem, b};
      if (t >= {1'b0, d}) begin
         div_step = {1'b1, 8'(t - {1'b0, d})};
      end else begin
         div_step = {1'b0, t[7:0]};
      end
   endfunction

   always_comb begin
      s1     = div_step(rem_ff, mag_ff[PROD_W-1], div_ff);
      s2     = div_step(s1[7:0], mag_ff[PROD_W-2], div_ff);
      mag_in = {mag_ff[PROD_W-3:0], s1[8], s2[8]};
      rem_in = s2[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ITER);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff <= dividend[PROD_W-1] ? PROD_W'(-dividend) : dividend;
         neg_ff <= dividend[PROD_W-1];
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         mag_ff <= mag_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? PROD_W'(-$signed(mag_ff)) : $signed(mag_ff);

endmodule

`default_nettype wire

[hw/rtl/axis_rate_level_pid_top.sv]
// Top level of the per-axis rate and self-levelling PID controller
//
//  channel  direction  handshake          payload
//  req      in         req_valid/ready    axis, command, gyro, tilt, mode, gains
//  rsp      out        rsp_valid/ready    axis_out, drive
//  csr      in         csr_we             csr_index, csr_wdata (24 bits)
//
// One request at a time. Rate mode runs longer than level mode, set by the
// divide by P in the two-bit-a-cycle divider. Divides by 80, 100 and 125 are
// reciprocal multiplies. Axis 3 is accepted and dropped with no response.
// Reset is synchronous; state memory reads as zero until written, no sweep.
// A result waiting on rsp does not stop the next request being taken; only
// the final write into the output register waits.
`default_nettype none
`include "axis_rate_level_pid_top_assert.svh"

module axis_rate_level_pid_top
   import arlp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_axis,
   input  wire logic signed [DATA_W-1:0] req_rate_command,
   input  wire logic signed [DATA_W-1:0] req_gyro_rate,
   input  wire logic signed [TILT_W-1:0] req_tilt_angle,
   input  wire logic                     req_level_mode,
   input  wire logic                     req_clear_level_integral,
   input  wire logic [7:0]               req_scaled_p,
   input  wire logic [7:0]               req_scaled_d,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [1:0]                    rsp_axis_out,
   output logic signed [DATA_W-1:0]      rsp_drive,
   input  wire logic                     csr_we,
   input  wire logic [2:0]               csr_index,
   input  wire logic [GAIN_W-1:0]        csr_wdata
);

   // configuration registers
   logic [GAIN_W-1:0]        gains_roll_ff;
   logic [GAIN_W-1:0]        gains_pitch_ff;
   logic [GAIN_W-1:0]        gains_yaw_ff;
   logic [GAIN_W-1:0]        gains_level_ff;
   logic signed [TRIM_W-1:0] trim_roll_ff;
   logic signed [TRIM_W-1:0] trim_pitch_ff;

   // sequencer
   pid_state_type state_ff;
   pid_state_type state_in;
   logic          go_ff;
   logic          go_in;
   logic          accept;
   logic          slot_free;

   // latched request
   logic [1:0]               ax_ff;
   logic signed [DATA_W-1:0] cmd_ff;
   logic signed [DATA_W-1:0] gyro_ff;
   logic signed [TILT_W-1:0] tilt_ff;
   logic                     lvl_ff;
   logic [7:0]               dp_ff;
   logic [7:0]               dd_ff;

   // working registers
   entry_type                ent_ff;
   logic signed [13:0]       err_ff;
   logic signed [13:0]       err_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] cq_ff;
   logic signed [DATA_W-1:0] pa_ff;
   logic signed [DATA_W-1:0] pa_in;
   logic signed [INT_W-1:0]  int_ff;
   logic signed [INT_W-1:0]  int_in;
   logic signed [DATA_W-1:0] iterm_ff;
   logic signed [DATA_W-1:0] pterm_ff;
   logic signed [DATA_W-1:0] pterm_in;
   logic signed [DATA_W-1:0] dsum_ff;
   logic signed [DATA_W-1:0] dsum_in;
   logic signed [DATA_W-1:0] delta;
   logic signed [DATA_W-1:0] dterm_ff;

   // output register
   logic                     rsp_valid_ff;
   logic [1:0]               rsp_axis_ff;
   logic signed [DATA_W-1:0] rsp_drive_ff;

   // gain selection
   logic [GAIN_W-1:0]        gsel;
   logic [7:0]               p_div;
   logic [7:0]               gi;
   logic [7:0]               lp;
   logic [7:0]               li;
   logic [7:0]               ld;
   logic signed [TRIM_W-1:0] trim_sel;

   // shared multiplier
   logic signed [DATA_W-1:0] mul_a;
   logic [7:0]               mul_b;
   logic signed [PROD_W:0]   mul_p;

   // constant divide operands
   logic signed [PROD_W-1:0] cdiv_num;
   logic [PROD_W-1:0]        cdiv_recip;

   // divider
   logic signed [PROD_W-1:0] div_num;
   logic [7:0]               div_den;
   logic                     div_done;
   logic signed [PROD_W-1:0] div_quot;

   // state memory
   mem_ctl_type mem_ctl;
   entry_type   mem_wr;
   entry_type   mem_rd;

   // truncating divide by a constant: magnitude times scaled reciprocal
   function automatic logic signed [PROD_W-1:0] recip_div(
         input logic signed [PROD_W-1:0] x, input logic [PROD_W-1:0] recip);
      logic [PROD_W-1:0]               mag;
      logic [2*PROD_W-1:0]             full;
      logic [2*PROD_W-RECIP_SHIFT-1:0] q;
      mag  = x[PROD_W-1] ? PROD_W'(-x) : PROD_W'(x);
      full = (2*PROD_W)'(mag) * (2*PROD_W)'(recip);
      q    = full[2*PROD_W-1:RECIP_SHIFT];
      recip_div = x[PROD_W-1] ? -PROD_W'(q) : PROD_W'(q);
   endfunction

   //---------------------------------------------------------------
   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         gains_roll_ff  <= GAINS_ROLL_RST;
         gains_pitch_ff <= GAINS_PITCH_RST;
         gains_yaw_ff   <= GAINS_YAW_RST;
         gains_level_ff <= GAINS_LEVEL_RST;
         trim_roll_ff   <= '0;
         trim_pitch_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_GAINS_ROLL:  gains_roll_ff  <= csr_wdata;
            REG_GAINS_PITCH: gains_pitch_ff <= csr_wdata;
            REG_GAINS_YAW:   gains_yaw_ff   <= csr_wdata;
            REG_GAINS_LEVEL: gains_level_ff <= csr_wdata;
            REG_TRIM_ROLL:   trim_roll_ff   <= csr_wdata[TRIM_W-1:0];
            REG_TRIM_PITCH:  trim_pitch_ff  <= csr_wdata[TRIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (axis_type'(ax_ff))
         AXIS_ROLL:  gsel = gains_roll_ff;
         AXIS_PITCH: gsel = gains_pitch_ff;
         default:    gsel = gains_yaw_ff;
      endcase
      // zero P gain divides as one
      p_div    = (gsel[23:16] == 8'd0) ? 8'd1 : gsel[23:16];
      gi       = gsel[15:8];
      lp       = gains_level_ff[23:16];
      li       = gains_level_ff[15:8];
      ld       = gains_level_ff[7:0];
      trim_sel = ax_ff[0] ? trim_pitch_ff : trim_roll_ff;
   end

   //---------------------------------------------------------------
   // sequencer: next state
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept && req_axis != AXIS_NONE) state_in = S_READ;
         S_READ:  state_in = S_LOAD;
         S_LOAD:  state_in = S_MUL_A;
         S_MUL_A: state_in = S_DIV_A;
         // level mode divides by 100 without waiting, rate mode waits on the divider
         S_DIV_A: if (lvl_ff || div_done) state_in = S_INT;
         S_INT:   state_in = lvl_ff ? S_MUL_B : S_DIV_B;
         S_DIV_B: state_in = S_MUL_B;
         S_MUL_B: state_in = S_MUL_C;
         S_MUL_C: state_in = S_DIV_C;
         S_DIV_C: state_in = S_DEL;
         S_DEL:   state_in = S_MUL_D;
         S_MUL_D: state_in = S_OUT;
         S_OUT:   if (slot_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      // divider kicks off on the first cycle of the rate-mode divide by P
      go_in = (state_in == S_DIV_A) && (state_ff != S_DIV_A) && !lvl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         go_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
      end
   end

   // sequencer: outputs
   always_comb begin
      req_ready         = (state_ff == S_IDLE);
      mem_ctl.rd_en     = (state_ff == S_READ);
      mem_ctl.wr_en     = (state_ff == S_DEL);
      mem_ctl.clr_angle = accept && req_clear_level_integral;
      mem_ctl.addr      = ax_ff;
      mul_a             = gyro_ff;
      mul_b             = dp_ff;
      div_num           = prod_ff;
      div_den           = p_div;
      cdiv_num          = prod_ff;
      cdiv_recip        = RECIP_80;
      unique case (state_ff)
         S_MUL_A: begin
            mul_a = lvl_ff ? DATA_W'(err_ff) : cmd_ff;
            mul_b = lvl_ff ? lp : CMD_SCALE;
         end
         S_MUL_B: begin
            mul_a = lvl_ff ? DATA_W'(int_ff) : cq_ff[DATA_W-1:0];
            mul_b = lvl_ff ? li : gi;
         end
         S_MUL_D: begin
            mul_a = dsum_ff;
            mul_b = dd_ff;
         end
         S_DIV_A: begin
            cdiv_recip = RECIP_100;
         end
         S_DIV_B: begin
            cdiv_num   = PROD_W'(int_ff);
            cdiv_recip = RECIP_125;
         end
         default: ;
      endcase
   end

   //---------------------------------------------------------------
   // datapath
   assign mul_p = mul_a * $signed({1'b0, mul_b});

   always_comb begin
      logic signed [16:0]       cmd2;
      logic signed [10:0]       cmdc;
      logic [10:0]              ld5;
      logic signed [11:0]       lim;
      logic signed [DATA_W-1:0] e;
      logic signed [DATA_W-1:0] asum;
      logic signed [16:0]       rsum;
      logic signed [INT_W-1:0]  aclamp;
      logic signed [INT_W-1:0]  rclamp;
      logic                     gyro_big;

      // angle error: clamped stick angle minus tilt plus trim
      cmd2 = {cmd_ff, 1'b0};
      if (cmd2 > CMD_CLAMP) begin
         cmdc = CMD_CLAMP;
      end else if (cmd2 < -CMD_CLAMP) begin
         cmdc = -CMD_CLAMP;
      end else begin
         cmdc = cmd2[10:0];
      end
      err_in = 14'(cmdc) - 14'(tilt_ff) + 14'(trim_sel);

      // level P term clamp at five times level D
      ld5 = 11'(ld) * 11'(P_CLAMP_MUL);
      lim = $signed({1'b0, ld5});
      if (cq_ff > PROD_W'(lim)) begin
         pa_in = DATA_W'(lim);
      end else if (cq_ff < -PROD_W'(lim)) begin
         pa_in = DATA_W'(-lim);
      end else begin
         pa_in = cq_ff[DATA_W-1:0];
      end
      if (!lvl_ff) begin
         pa_in = cmd_ff;
      end

      asum = DATA_W'(ent_ff.angle_int) + DATA_W'(err_ff);
      if (asum > DATA_W'(LEVEL_INT_MAX)) begin
         aclamp = LEVEL_INT_MAX;
      end else if (asum < -DATA_W'(LEVEL_INT_MAX)) begin
         aclamp = -LEVEL_INT_MAX;
      end else begin
         aclamp = asum[INT_W-1:0];
      end

      // rate error and integral, dropped on fast rotation
      e        = $signed(div_quot[DATA_W-1:0]) - gyro_ff;
      rsum     = 17'(ent_ff.rate_int) + 17'(e);
      gyro_big = (gyro_ff > GYRO_CUT) || (gyro_ff < -GYRO_CUT);
      if (rsum > 17'(RATE_INT_MAX)) begin
         rclamp = RATE_INT_MAX;
      end else if (rsum < -17'(RATE_INT_MAX)) begin
         rclamp = -RATE_INT_MAX;
      end else begin
         rclamp = rsum[INT_W-1:0];
      end
      if (gyro_big) begin
         rclamp = '0;
      end
      int_in = lvl_ff ? aclamp : rclamp;

      // gyro damping and delta history
      pterm_in = pa_ff - $signed(cq_ff[DATA_W-1:0]);
      delta    = gyro_ff - ent_ff.prev_gyro;
      dsum_in  = ent_ff.older_delta + ent_ff.oldest_delta + delta;

      mem_wr.prev_gyro    = gyro_ff;
      mem_wr.older_delta  = delta;
      mem_wr.oldest_delta = ent_ff.older_delta;
      mem_wr.rate_int     = lvl_ff ? ent_ff.rate_int : int_ff;
      mem_wr.angle_int    = lvl_ff ? int_ff : ent_ff.angle_int;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ax_ff   <= req_axis;
         cmd_ff  <= req_rate_command;
         gyro_ff <= req_gyro_rate;
         tilt_ff <= req_tilt_angle;
         lvl_ff  <= req_level_mode && (req_axis == AXIS_ROLL || req_axis == AXIS_PITCH);
         dp_ff   <= req_scaled_p;
         dd_ff   <= req_scaled_d;
      end
      unique case (state_ff)
         S_LOAD: begin
            ent_ff <= mem_rd;
            err_ff <= err_in;
         end
         S_MUL_A, S_MUL_C: prod_ff <= PROD_W'(mul_p);
         // constant divides; the rate-mode value in S_DIV_A goes unused
         S_DIV_A, S_DIV_B, S_DIV_C: cq_ff <= recip_div(cdiv_num, cdiv_recip);
         S_INT: begin
            pa_ff  <= pa_in;
            int_ff <= int_in;
         end
         S_MUL_B: begin
            iterm_ff <= lvl_ff ? DATA_W'(mul_p >>> LEVEL_I_SHIFT)
                               : DATA_W'(mul_p >>> RATE_I_SHIFT);
         end
         S_DEL: begin
            pterm_ff <= pterm_in;
            dsum_ff  <= dsum_in;
         end
         S_MUL_D: dterm_ff <= DATA_W'(mul_p >>> D_SHIFT);
         default: ;
      endcase
   end

   //---------------------------------------------------------------
   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_OUT && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && slot_free) begin
         rsp_axis_ff  <= ax_ff;
         rsp_drive_ff <= pterm_ff + iterm_ff - dterm_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_axis_out = rsp_axis_ff;
   assign rsp_drive    = rsp_drive_ff;

   //---------------------------------------------------------------
   arlp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (go_ff),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quot)
   );

   arlp_state_mem u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .wr_data (mem_wr),
      .rd_data (mem_rd)
   );

   //---------------------------------------------------------------
   // checks
   `ARLP_ASSERT_NEXT(a_skip_unused_axis, accept && req_axis == AXIS_NONE, req_ready, "unused axis not dropped")
   `ARLP_ASSERT_IMPL(a_div_done_in_div, div_done, state_ff == S_DIV_A || state_ff == S_DIV_B || state_ff == S_DIV_C, "divider result outside a divide state")
   `ARLP_ASSERT_IMPL(a_rate_int_range, mem_ctl.wr_en, mem_wr.rate_int <= RATE_INT_MAX && mem_wr.rate_int >= -RATE_INT_MAX, "rate integral out of range")
   `ARLP_ASSERT_IMPL(a_angle_int_range, mem_ctl.wr_en && lvl_ff, mem_wr.angle_int <= LEVEL_INT_MAX && mem_wr.angle_int >= -LEVEL_INT_MAX, "angle integral out of range")

endmodule

`default_nettype wire
